>>> rtl/core/vffs_pkg.sv
// Package for the video frame fade scaler: field widths, fixed-point
// constants and configuration register indexes. No dependencies.
`default_nettype none

package vffs_pkg;

  // Field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned FactorW = 17;
  localparam int unsigned FrameW  = 25;
  localparam int unsigned StartW  = 24;
  localparam int unsigned CountW  = 17;
  localparam int unsigned StepW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  // Width of the rounding datapath: product plus 10.16 rounding term
  localparam int unsigned AccW = 26;

  // 1.16 factor constants
  localparam logic [FactorW-1:0] FACTOR_MAX  = 17'd65535;
  localparam logic [FactorW-1:0] FACTOR_ONE  = 17'd65536;
  localparam logic [FactorW-1:0] FACTOR_ZERO = 17'd0;
  localparam logic [FrameW-1:0]  FRAME_MAX   = 25'h1FF_FFFF;

  // Rounding terms: 0.5 for luma, 128.5 for chroma (both 10.16)
  localparam logic [AccW-1:0] LUMA_ROUND   = 26'd32768;
  localparam logic [AccW-1:0] CHROMA_ROUND = 26'd8421376;

  // Configuration reset values
  localparam logic [StartW-1:0] START_RST = 24'd0;
  localparam logic [CountW-1:0] COUNT_RST = 17'd1;
  localparam logic [StepW-1:0]  STEP_RST  = 17'd65536;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DIRECTION = 2'd0,
    REG_START     = 2'd1,
    REG_COUNT     = 2'd2,
    REG_STEP      = 2'd3
  } cfg_reg_t;

  // Fade direction codes
  typedef enum logic {
    DIR_FADE_IN  = 1'b0,
    DIR_FADE_OUT = 1'b1
  } fade_dir_t;

  // Per-transfer event from the input side to the fade controller
  typedef struct packed {
    logic accept;
    logic frame_end;
  } in_evt_t;

endpackage : vffs_pkg

`default_nettype wire

>>> rtl/core/vffs_if.sv
// Stream channel interfaces for the fade scaler: sample input and result
// output, each valid/ready with payload. Depends on vffs_pkg.
`default_nettype none

interface vffs_in_if
  import vffs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_in;
  logic               is_chroma;
  logic               frame_end;

  modport source (output valid, sample_in, is_chroma, frame_end, input ready);
  modport sink   (input valid, sample_in, is_chroma, frame_end, output ready);
endinterface : vffs_in_if

interface vffs_out_if
  import vffs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample_out;
  logic               frame_end_out;

  modport source (output valid, sample_out, frame_end_out, input ready);
  modport sink   (input valid, sample_out, frame_end_out, output ready);
endinterface : vffs_out_if

`default_nettype wire

>>> rtl/core/vffs_fade_ctrl.sv
// Fade controller: configuration registers, fade factor and frame counter.
// Depends on vffs_pkg.
`default_nettype none

module vffs_fade_ctrl
  import vffs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire in_evt_t             evt,
  output logic [FactorW-1:0]       factor
);

  fade_dir_t           dir_r,    dir_nxt;
  logic [StartW-1:0]   start_r,  start_nxt;
  logic [CountW-1:0]   count_r,  count_nxt;
  logic [StepW-1:0]    step_r,   step_nxt;
  logic [FactorW-1:0]  factor_r, factor_nxt;
  logic [FrameW-1:0]   frame_r,  frame_nxt;

  logic [FrameW:0]     stop;
  logic                in_window;
  logic [FactorW:0]    sum_up;
  logic [FactorW:0]    moved;
  logic [FactorW-1:0]  clipped;

  // Factor update for one frame end
  always_comb begin
    stop      = {{(FrameW+1-StartW){1'b0}}, start_r} + {{(FrameW+1-CountW){1'b0}}, count_r};
    in_window = (frame_r >= {{(FrameW-StartW){1'b0}}, start_r}) &&
                ({1'b0, frame_r} <= stop);
    sum_up    = {1'b0, factor_r} + {1'b0, step_r};
    moved     = {1'b0, factor_r};
    if (in_window) begin
      if (dir_r == DIR_FADE_OUT) begin
        moved = (step_r >= factor_r) ? '0 : {1'b0, factor_r - step_r};
      end else begin
        moved = sum_up;
      end
    end
    clipped = (moved > {1'b0, FACTOR_MAX}) ? FACTOR_MAX : moved[FactorW-1:0];
  end

  // Next state: register writes restart on direction, frame ends move factor
  always_comb begin
    dir_nxt    = dir_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    factor_nxt = factor_r;
    frame_nxt  = frame_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIRECTION: begin
          dir_nxt    = fade_dir_t'(cfg_data[0]);
          factor_nxt = cfg_data[0] ? FACTOR_ONE : FACTOR_ZERO;
          frame_nxt  = '0;
        end
        REG_START: start_nxt = cfg_data[StartW-1:0];
        REG_COUNT: count_nxt = cfg_data[CountW-1:0];
        REG_STEP:  step_nxt  = cfg_data[StepW-1:0];
        default: ;
      endcase
    end else if (evt.accept && evt.frame_end) begin
      factor_nxt = clipped;
      if (frame_r != FRAME_MAX) begin
        frame_nxt = frame_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= DIR_FADE_IN;
      start_r  <= START_RST;
      count_r  <= COUNT_RST;
      step_r   <= STEP_RST;
      factor_r <= FACTOR_ZERO;
      frame_r  <= '0;
    end else begin
      dir_r    <= dir_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      step_r   <= step_nxt;
      factor_r <= factor_nxt;
      frame_r  <= frame_nxt;
    end
  end

  assign factor = factor_r;

endmodule : vffs_fade_ctrl

`default_nettype wire

>>> rtl/core/vffs_scale_pipe.sv
// Two-stage sample datapath: input register with factor snapshot, then
// multiply/round into the result register. Depends on vffs_pkg, vffs_if.
`default_nettype none

module vffs_scale_pipe
  import vffs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [FactorW-1:0] factor,
  vffs_in_if.sink                 in_ch,
  vffs_out_if.source              out_ch
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [SampleW-1:0] s1_sample_r;
  logic               s1_chroma_r;
  logic               s1_fend_r;
  logic [FactorW-1:0] s1_factor_r;

  logic               out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_sample_r;
  logic               out_fend_r;

  logic               out_advance;
  logic               s1_advance;
  logic               in_xfer;

  logic [AccW-1:0]    prod;
  logic [AccW-1:0]    acc;
  logic [SampleW-1:0] scaled;

  // Stage handshakes: each stage moves when the next one is free or draining
  assign out_advance  = !out_valid_r || out_ch.ready;
  assign s1_advance   = !s1_valid_r || out_advance;
  // No transfer in while reset is held
  assign in_ch.ready  = s1_advance && rst_n;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = s1_advance ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_advance ? s1_valid_r : (out_valid_r && !out_ch.ready);

  // Scale: luma s*f + 0.5, chroma s*f - 128*f + 128.5, then take the integer part
  always_comb begin
    prod = AccW'({{(AccW-SampleW){1'b0}}, s1_sample_r} *
                 {{(AccW-FactorW){1'b0}}, s1_factor_r});
    if (s1_chroma_r) begin
      acc = prod + CHROMA_ROUND - {{(AccW-FactorW-7){1'b0}}, s1_factor_r, 7'b0};
    end else begin
      acc = prod + LUMA_ROUND;
    end
    // Factor of 65535 or more (just below unity) passes the sample through
    scaled = (s1_factor_r >= FACTOR_MAX) ? s1_sample_r : acc[16 +: SampleW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_ch.sample_in;
      s1_chroma_r <= in_ch.is_chroma;
      s1_fend_r   <= in_ch.frame_end;
      s1_factor_r <= factor;
    end
    if (out_advance && s1_valid_r) begin
      out_sample_r <= scaled;
      out_fend_r   <= s1_fend_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = out_sample_r;
  assign out_ch.frame_end_out = out_fend_r;

endmodule : vffs_scale_pipe

`default_nettype wire

>>> rtl/core/video_frame_fade_scaler.sv
// Video fade-in/fade-out scaler top level: fade controller plus sample pipe.
// Depends on vffs_pkg, vffs_if, vffs_fade_ctrl, vffs_scale_pipe.
//
// Scales a stream of 8-bit video components by a 1.16 fade factor, one
// component per clock while the output is not stalled: a new sample can be
// taken every cycle, and a sample passes the input register, then
// multiply/round into the output register, before it is transferred out.
// When both registers are full, in_ch.ready follows out_ch.ready through
// combinational logic, so a stalled receiver stalls the sender in the same cycle.
// Luma/RGB samples become (s*f+0.5), chroma samples ((s-128)*f+128.5), both
// truncated; at a factor of 65535 or more samples pass unchanged. The factor
// used for a sample is the one in force when it is transferred in; on the
// transfer of a sample marked frame_end the factor steps by fade_step when
// the frame index lies in [fade_start, fade_start+frame_count], is clipped
// to 0..65535, and the frame index counts up, saturating. Writing
// fade_direction restarts the fade (factor 0 fading in, 65536 fading out).
// Registers: 0 fade_direction, 1 fade_start, 2 frame_count, 3 fade_step;
// write them only while the block is empty.
`default_nettype none

module video_frame_fade_scaler
  import vffs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  vffs_in_if.sink                  in_ch,
  vffs_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [FactorW-1:0] factor;
  in_evt_t            evt;

  // Input transfer event drives the frame-end bookkeeping
  assign evt.accept    = in_ch.valid && in_ch.ready;
  assign evt.frame_end = in_ch.frame_end;

  vffs_fade_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .factor    (factor)
  );

  vffs_scale_pipe u_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .factor (factor),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule : video_frame_fade_scaler

`default_nettype wire
